// File: hdl/assert_macros.svh
// Assertion macros shared by the integer to ASCII radix unit.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/itar_pkg.sv
// Package of the integer to ASCII radix unit: command and status types,
// character constants and the digit to character function. No dependencies.
package itar_pkg;

    localparam int VALUE_WIDTH_DEF = 16;
    localparam int RADIX_W         = 6;
    localparam int CHAR_W          = 7;

    localparam logic [RADIX_W-1:0] RADIX_RESET  = 6'd10;
    localparam logic [RADIX_W-1:0] BASE_DECIMAL = 6'd10;
    localparam logic [RADIX_W-1:0] BASE_MIN     = 6'd2;
    localparam logic [RADIX_W-1:0] BASE_MAX     = 6'd36;
    localparam logic [RADIX_W-1:0] DIGIT_MAX_DEC = 6'd9;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_A     = 7'h61;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;

    // Controller to datapath
    typedef struct packed {
        logic load;        // take the input value, start the first division
        logic div_step;    // one quotient bit of the shift-subtract divider
        logic push;        // store the remainder as a digit, start next division
        logic emit_sign;   // load '-' into the output register
        logic emit_digit;  // pop a digit into the output register
    } itar_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic div_done;    // the step now running is the last of this division
        logic quot_zero;   // quotient left by the finished division is zero
        logic neg;         // text starts with a sign
        logic stack_one;   // one digit left on the stack
        logic out_free;    // output register can take a character this cycle
    } itar_status_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d > DIGIT_MAX_DEC) begin
            c = CHAR_A + CHAR_W'(d - BASE_DECIMAL);
        end else begin
            c = CHAR_ZERO + CHAR_W'(d);
        end
        return c;
    endfunction

endpackage

// File: hdl/integer_to_ascii_radix_unit.sv
// Integer to ASCII radix unit: takes one signed VALUE_WIDTH-bit integer per
// transfer and streams its text in the base held in the radix register (2..36;
// 0 and 1 act as 2, above 36 acts as 36), most significant character first,
// with m_tlast on the final one. Base 10 prints a leading '-' for negative
// values, the most negative value included; every other base prints the bit
// pattern as unsigned. Digits above 9 are 'a'..'z'; zero prints "0"; no
// terminator. A bit-serial shift-subtract divider produces one quotient bit a
// cycle; each digit takes one full division and a push of the remainder onto
// the digit stack, and the characters then go out as the output register
// frees. The next item is taken once the last character sits in the output
// register. The radix register resets to 10 and is written by
// cfg_wr_en/cfg_wr_data; the user must write it only while the unit is idle,
// as the block itself does not enforce it.
// Depends on itar_pkg, itar_ctrl and itar_dp.

module integer_to_ascii_radix_unit
    import itar_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [RADIX_W-1:0]                 cfg_wr_data,  // radix
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]   s_tdata,      // value, zero padding
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [7:0]                         m_tdata,      // character, zero bit
    output logic                               m_tlast
);

    itar_cmd_t          cmd;
    itar_status_t       status;
    logic [CHAR_W-1:0]  character;

    itar_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    itar_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .value       (s_tdata[VALUE_WIDTH-1:0]),
        .cmd         (cmd),
        .status      (status),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_character (character),
        .m_last      (m_tlast)
    );

    assign m_tdata = {1'b0, character};

endmodule

// File: hdl/itar_ctrl.sv
// Controller of the integer to ASCII radix unit: sequences load, division,
// digit push and character output. Depends on itar_pkg and assert_macros.svh.
`include "assert_macros.svh"

module itar_ctrl
    import itar_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  itar_status_t status,
    output itar_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_PUSH = 3'd2;
    localparam logic [2:0] ST_SIGN = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_done) begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                cmd.push = 1'b1;
                // keep dividing until the quotient runs out
                if (!status.quot_zero) begin
                    state_next = ST_DIV;
                end else if (status.neg) begin
                    state_next = ST_SIGN;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (status.out_free) begin
                    cmd.emit_sign = 1'b1;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit_digit = 1'b1;
                    if (status.stack_one) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `ASSERT_NEXT(a_div_to_push, aclk, aresetn, state_reg == ST_DIV && status.div_done, state_reg == ST_PUSH, "division did not end in push")
    `ASSERT_NEXT(a_push_loops, aclk, aresetn, state_reg == ST_PUSH && !status.quot_zero, state_reg == ST_DIV, "nonzero quotient not divided again")

endmodule

// File: hdl/itar_dp.sv
// Datapath of the integer to ASCII radix unit: radix register, bit-serial
// divider, digit stack and output register. Depends on itar_pkg, assert_macros.svh.
`include "assert_macros.svh"

module itar_dp
    import itar_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [RADIX_W-1:0]      cfg_wr_data,
    input  logic [VALUE_WIDTH-1:0]  value,
    input  itar_cmd_t               cmd,
    output itar_status_t            status,
    input  logic                    m_tready,
    output logic                    m_tvalid,
    output logic [CHAR_W-1:0]       m_character,
    output logic                    m_last
);

    localparam int CW = $clog2(VALUE_WIDTH);
    localparam int SW = $clog2(VALUE_WIDTH + 1);

    logic [RADIX_W-1:0]     radix_reg;
    logic [RADIX_W-1:0]     base_reg;
    logic                   neg_reg;
    logic [VALUE_WIDTH-1:0] mag_reg;
    logic [RADIX_W-1:0]     rem_reg;
    logic [CW-1:0]          cnt_reg;
    logic [SW-1:0]          sp_reg;
    logic [RADIX_W-1:0]     digit_reg [VALUE_WIDTH];
    logic                   m_tvalid_reg;
    logic [CHAR_W-1:0]      m_char_reg;
    logic                   m_last_reg;

    logic [RADIX_W-1:0]     eff_base;
    logic                   load_neg;
    logic [RADIX_W:0]       trial;
    logic                   trial_ge;
    logic [RADIX_W:0]       trial_diff;
    logic [RADIX_W-1:0]     rem_next;
    logic [SW-1:0]          sp_dec;

    always_comb begin
        if (radix_reg < BASE_MIN) begin
            eff_base = BASE_MIN;
        end else if (radix_reg > BASE_MAX) begin
            eff_base = BASE_MAX;
        end else begin
            eff_base = radix_reg;
        end
    end

    assign load_neg   = value[VALUE_WIDTH-1] && (eff_base == BASE_DECIMAL);
    assign trial      = {rem_reg, mag_reg[VALUE_WIDTH-1]};
    assign trial_ge   = trial >= {1'b0, base_reg};
    assign trial_diff = trial - {1'b0, base_reg};
    assign rem_next   = trial_ge ? trial_diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
    assign sp_dec     = sp_reg - SW'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= RADIX_RESET;
        end else if (cfg_wr_en) begin
            radix_reg <= cfg_wr_data;
        end
    end

    // Divider and digit stack
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg <= '0;
        end else begin
            if (cmd.load) begin
                base_reg <= eff_base;
                neg_reg  <= load_neg;
                mag_reg  <= load_neg ? (~value + VALUE_WIDTH'(1)) : value;
                rem_reg  <= '0;
                cnt_reg  <= '0;
                sp_reg   <= '0;
            end
            if (cmd.div_step) begin
                mag_reg <= {mag_reg[VALUE_WIDTH-2:0], trial_ge};
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg + CW'(1);
            end
            if (cmd.push) begin
                digit_reg[sp_reg[CW-1:0]] <= rem_reg;
                sp_reg  <= sp_reg + SW'(1);
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            if (cmd.emit_digit) begin
                sp_reg <= sp_dec;
            end
        end
    end

    // Output register: hold until the transfer, refill on the same edge
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit_sign || cmd.emit_digit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_sign) begin
            m_char_reg <= CHAR_MINUS;
            m_last_reg <= 1'b0;
        end else if (cmd.emit_digit) begin
            m_char_reg <= digit_char(digit_reg[sp_dec[CW-1:0]]);
            m_last_reg <= (sp_reg == SW'(1));
        end
    end

    assign status.div_done  = (cnt_reg == CW'(VALUE_WIDTH - 1));
    assign status.quot_zero = (mag_reg == '0);
    assign status.neg       = neg_reg;
    assign status.stack_one = (sp_reg == SW'(1));
    assign status.out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid    = m_tvalid_reg;
    assign m_character = m_char_reg;
    assign m_last      = m_last_reg;

    `ASSERT_IMPL(a_no_overflow, aclk, aresetn, cmd.push, sp_reg < SW'(VALUE_WIDTH), "digit stack overflow")
    `ASSERT_IMPL(a_no_underflow, aclk, aresetn, cmd.emit_digit, sp_reg != '0, "digit stack underflow")
    `ASSERT_IMPL(a_sign_only_neg, aclk, aresetn, cmd.emit_sign, neg_reg && base_reg == BASE_DECIMAL, "sign emitted for non-negative or non-decimal")

endmodule
